[rtl/core/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the box blur row filter
// Pixel and result beat layouts, configuration register indexes and reset
// values.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned QUO_W      = PIX_W;
  localparam int unsigned HALF_W     = 4;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [HALF_W-1:0] HALF_WIDTH_RST = 4'd1;
  localparam logic [ROW_W-1:0]  ROW_WIDTH_RST  = 13'd4096;

  typedef enum logic [0:0] {
    CFG_HALF_WIDTH = 1'b0,
    CFG_ROW_WIDTH  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             run_last;
    logic             row_last;
    logic             short_row;
  } pix_out_t;

endpackage

[rtl/core/bbr_div_cell.sv]
// ----------------------------------------------------------------------------
// bbr_div_cell: one quotient bit of the window mean divider
// Restoring division step for all three channels against a shared divisor,
// registered, with the beat's side information passed along unchanged.
// ----------------------------------------------------------------------------
module bbr_div_cell #(
  parameter int unsigned SumW = 13,
  parameter int unsigned DivW = 5,
  parameter int unsigned Bit  = 0,
  parameter type         meta_t = logic
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                en_i,
  input  logic                                                valid_i,
  input  logic [bbr_pkg::NUM_CH-1:0][SumW-1:0]                rem_i,
  input  logic [bbr_pkg::NUM_CH-1:0][bbr_pkg::QUO_W-1:0]      quo_i,
  input  logic [DivW-1:0]                                     div_i,
  input  meta_t                                               meta_i,
  output logic                                                valid_o,
  output logic [bbr_pkg::NUM_CH-1:0][SumW-1:0]                rem_o,
  output logic [bbr_pkg::NUM_CH-1:0][bbr_pkg::QUO_W-1:0]      quo_o,
  output logic [DivW-1:0]                                     div_o,
  output meta_t                                               meta_o
);
  import bbr_pkg::*;

  localparam int unsigned TrialW = SumW + QUO_W;

  logic [TrialW-1:0]                 trial;
  logic [NUM_CH-1:0][SumW-1:0]       rem_d;
  logic [NUM_CH-1:0][QUO_W-1:0]      quo_d;
  logic                              valid_q;
  logic [NUM_CH-1:0][SumW-1:0]       rem_q;
  logic [NUM_CH-1:0][QUO_W-1:0]      quo_q;
  logic [DivW-1:0]                   div_q;
  meta_t                             meta_q;

  assign trial = TrialW'(div_i) << Bit;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      quo_d[ch] = quo_i[ch];
      if (TrialW'(rem_i[ch]) >= trial) begin
        rem_d[ch]      = rem_i[ch] - trial[SumW-1:0];
        quo_d[ch][Bit] = 1'b1;
      end else begin
        rem_d[ch]      = rem_i[ch];
        quo_d[ch][Bit] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_i;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign meta_o  = meta_q;

endmodule

[rtl/core/box_blur_row_filter.sv]
// ----------------------------------------------------------------------------
// box_blur_row_filter: horizontal box blur of an RGB pixel row
// Running-sum box filter over a window of 2*half_width+1 pixels, with the
// mean taken by a chain of divider cells.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel (valid/ready), one beat per
// pixel. Blurred pixels leave on the out channel. A pixel beat causes zero,
// one or a burst of result beats: nothing while the window fills, a burst of
// half_width at the first full window, one per pixel after that, and the
// remaining outputs of the row at its last pixel. The last beat of each burst
// has run_last set, and the row's final beat has row_last set. Rows shorter
// than the window pass each pixel through with short_row set.
// An input beat reaches its first result beat through the entry stage that
// registers the running sums, one cell per quotient bit in the 8-cell divider
// chain and the output register. The chain takes one pixel per cycle while
// each pixel yields at most one result and the out channel does not stall; a
// burst of k beats holds the input while the output register repeats the mean.
// A stall on the out channel freezes the whole chain and drops in_ready_o.
// Reset clears the sums and column count and sets half_width to 1 and
// row_width to 4096; the window line is not cleared. Any register write
// restarts the row.
// ----------------------------------------------------------------------------
module box_blur_row_filter #(
  parameter int unsigned MAX_HALF      = 15,
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  bbr_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [bbr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bbr_pkg::pix_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bbr_pkg::pix_out_t                   out_data_o
);
  import bbr_pkg::*;

  localparam int unsigned Win   = 2 * MAX_HALF + 1;
  localparam int unsigned NW    = $clog2(Win + 1);
  localparam int unsigned HW    = $clog2(MAX_HALF + 1);
  localparam int unsigned IW    = $clog2(Win);
  localparam int unsigned SW    = $clog2((2 ** PIX_W - 1) * Win + 1);
  localparam int unsigned CLW   = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned NStg  = QUO_W;

  typedef struct packed {
    logic [NW-1:0] count;
    logic          row_last;
    logic          short_row;
  } meta_t;

  // Configuration and row state
  logic [HALF_W-1:0]           half_width_q, half_width_d;
  logic [ROW_W-1:0]            row_width_q, row_width_d;
  logic [CLW-1:0]              col_q, col_d;
  logic [NUM_CH-1:0][SW-1:0]   sum_q, sum_d, sum_new;
  pix_in_t                     win_q [Win];

  logic [HW-1:0]               h;
  logic [NW-1:0]               n;
  logic [WW-1:0]               w;
  logic                        last, is_short, full, at_fill, evict;
  logic [NW-1:0]               count;
  pix_in_t                     old_pix;
  logic [NUM_CH-1:0][PIX_W-1:0] new_ch, old_ch;

  logic                        en, accept;

  // Divider chain
  logic                              ch_valid [NStg+1];
  logic [NUM_CH-1:0][SW-1:0]         ch_rem   [NStg+1];
  logic [NUM_CH-1:0][QUO_W-1:0]      ch_quo   [NStg+1];
  logic [NW-1:0]                     ch_div   [NStg+1];
  meta_t                             ch_meta  [NStg+1];

  logic                              s0_valid_q;
  logic [NUM_CH-1:0][SW-1:0]         s0_rem_q, s0_rem_d;
  logic [NW-1:0]                     s0_div_q, s0_div_d;
  meta_t                             s0_meta_q, s0_meta_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic [NW-1:0]                     out_cnt_q, out_cnt_d;
  logic [NUM_CH-1:0][QUO_W-1:0]      out_quo_q;
  logic                              out_row_last_q, out_short_q;
  logic                              tail_load;

  // Effective settings and per-pixel decisions
  always_comb begin
    if (32'(half_width_q) > MAX_HALF) begin
      h = HW'(MAX_HALF);
    end else begin
      h = HW'(half_width_q);
    end
    n = NW'(2 * 32'(h) + 1);
    if (row_width_q == '0) begin
      w = WW'(1);
    end else if (32'(row_width_q) > MAX_ROW_WIDTH) begin
      w = WW'(MAX_ROW_WIDTH);
    end else begin
      w = WW'(row_width_q);
    end
    last     = (32'(col_q) + 32'd1) >= 32'(w);
    is_short = 32'(w) < 32'(n);
    full     = (32'(col_q) + 32'd1) >= 32'(n);
    at_fill  = (32'(col_q) + 32'd1) == 32'(n);
    evict    = 32'(col_q) >= 32'(n);

    if (!full) begin
      count = '0;
    end else if (last) begin
      count = at_fill ? n : NW'(32'(h) + 2);
    end else begin
      count = at_fill ? NW'(h) : NW'(1);
    end
  end

  // The pixel received n beats ago sits at tap n-1 of the window line.
  assign old_pix = win_q[IW'(2 * 32'(h))];
  assign new_ch  = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  assign old_ch  = {old_pix.red_in, old_pix.green_in, old_pix.blue_in};

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_new[ch] = sum_q[ch] + SW'(new_ch[ch]) - (evict ? SW'(old_ch[ch]) : SW'(0));
    end
  end

  assign en         = !out_valid_q || (out_ready_i && out_cnt_q == NW'(1));
  assign accept     = in_valid_i && en;
  assign in_ready_o = en;

  always_comb begin
    half_width_d = half_width_q;
    row_width_d  = row_width_q;
    col_d        = col_q;
    sum_d        = sum_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HALF_WIDTH: half_width_d = cfg_data_i[HALF_W-1:0];
        CFG_ROW_WIDTH:  row_width_d  = cfg_data_i[ROW_W-1:0];
        default:        half_width_d = half_width_q;
      endcase
      col_d = '0;
      sum_d = '0;
    end else if (accept) begin
      if (last) begin
        col_d = '0;
        sum_d = '0;
      end else begin
        col_d = CLW'(32'(col_q) + 32'd1);
        if (!is_short) begin
          sum_d = sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RST;
      row_width_q  <= ROW_WIDTH_RST;
      col_q        <= '0;
      sum_q        <= '0;
    end else begin
      half_width_q <= half_width_d;
      row_width_q  <= row_width_d;
      col_q        <= col_d;
      sum_q        <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_short) begin
      win_q[0] <= in_data_i;
      for (int k = 1; k < Win; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // Entry stage of the divider chain. A short row feeds the raw pixel with a
  // divisor of one, so the chain hands it back unchanged.
  always_comb begin
    s0_meta_d.row_last = last;
    if (is_short) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s0_rem_d[ch] = SW'(new_ch[ch]);
      end
      s0_div_d            = NW'(1);
      s0_meta_d.count     = NW'(1);
      s0_meta_d.short_row = 1'b1;
    end else begin
      s0_rem_d            = sum_new;
      s0_div_d            = n;
      s0_meta_d.count     = count;
      s0_meta_d.short_row = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_rem_q  <= s0_rem_d;
      s0_div_q  <= s0_div_d;
      s0_meta_q <= s0_meta_d;
    end
  end

  assign ch_valid[0] = s0_valid_q;
  assign ch_rem[0]   = s0_rem_q;
  assign ch_quo[0]   = '0;
  assign ch_div[0]   = s0_div_q;
  assign ch_meta[0]  = s0_meta_q;

  for (genvar k = 0; k < NStg; k++) begin : g_div
    bbr_div_cell #(
      .SumW   (SW),
      .DivW   (NW),
      .Bit    (NStg - 1 - k),
      .meta_t (meta_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ch_valid[k]),
      .rem_i   (ch_rem[k]),
      .quo_i   (ch_quo[k]),
      .div_i   (ch_div[k]),
      .meta_i  (ch_meta[k]),
      .valid_o (ch_valid[k+1]),
      .rem_o   (ch_rem[k+1]),
      .quo_o   (ch_quo[k+1]),
      .div_o   (ch_div[k+1]),
      .meta_o  (ch_meta[k+1])
    );
  end

  // Output register repeats the mean for every beat of a burst.
  assign tail_load = ch_valid[NStg] && ch_meta[NStg].count != '0;

  always_comb begin
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    if (en) begin
      out_valid_d = tail_load;
      out_cnt_d   = ch_meta[NStg].count;
    end else if (out_ready_i) begin
      out_cnt_d = out_cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && tail_load) begin
      out_quo_q      <= ch_quo[NStg];
      out_row_last_q <= ch_meta[NStg].row_last;
      out_short_q    <= ch_meta[NStg].short_row;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.red_out   = out_quo_q[2];
  assign out_data_o.green_out = out_quo_q[1];
  assign out_data_o.blue_out  = out_quo_q[0];
  assign out_data_o.run_last  = out_cnt_q == NW'(1);
  assign out_data_o.row_last  = out_row_last_q && out_cnt_q == NW'(1);
  assign out_data_o.short_row = out_short_q;

endmodule
